### src/bce_pkg.sv
// shared constants, types and command records for the board evaluator
// depends on nothing; used by bce_ctrl, bce_datapath and board_cnn_evaluator
`timescale 1ns / 1ps

package bce_pkg;

    // network shape
    localparam int PIECE_KINDS   = 6;
    localparam int NUM_FILTERS   = 8;
    localparam int KERNEL_WIDTH  = 3;
    localparam int FRACTION_BITS = 8;

    // board geometry and output scaling
    localparam int BOARD_SIDE   = 8;
    localparam int SQUARES      = BOARD_SIDE * BOARD_SIDE;
    localparam int SQ_W         = 6;
    localparam int SIDE_W       = 3;
    localparam int SCALE_FACTOR = 100;
    localparam int PAD_OFFSET   = (KERNEL_WIDTH - 1) / 2;

    // store depths and index widths
    localparam int TAPS_PER_FILTER = KERNEL_WIDTH * KERNEL_WIDTH * PIECE_KINDS;
    localparam int TAP_DEPTH       = NUM_FILTERS * TAPS_PER_FILTER;
    localparam int MAP_DEPTH       = NUM_FILTERS * SQUARES;
    localparam int TAP_AW          = $clog2(TAP_DEPTH);
    localparam int MAP_AW          = $clog2(MAP_DEPTH);
    localparam int PK_W            = (PIECE_KINDS > 1) ? $clog2(PIECE_KINDS) : 1;
    localparam int KW_W            = (KERNEL_WIDTH > 1) ? $clog2(KERNEL_WIDTH) : 1;

    // field widths
    localparam int WEIGHT_W = 16;
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int PIECE_W  = 3;
    localparam int BOARD_W  = 64;
    localparam int SCORE_W  = 24;

    // arithmetic widths
    localparam int SUM_W  = WEIGHT_W + $clog2(TAPS_PER_FILTER + 1) + 1;
    localparam int PROD_W = SUM_W + WEIGHT_W;
    localparam int TOT_W  = PROD_W + MAP_AW + 1;
    localparam int SC_W   = TOT_W + 8;

    // opcode and weight kind codes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PLANE  = 1'b1;
    localparam logic [KIND_W-1:0] KIND_TAP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIAS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DENSE = 2'd2;

    // packed input tdata layout, lowest bit first
    localparam int IN_DATA_W = 160;
    localparam int KIND_LSB  = 0;
    localparam int INDEX_LSB = KIND_LSB + KIND_W;
    localparam int VALUE_LSB = INDEX_LSB + INDEX_W;
    localparam int PIECE_LSB = VALUE_LSB + WEIGHT_W;
    localparam int OWN_LSB   = PIECE_LSB + PIECE_W;
    localparam int ENEMY_LSB = OWN_LSB + BOARD_W;
    localparam int FLIP_LSB  = ENEMY_LSB + BOARD_W;

    // commands from controller to datapath
    typedef struct packed {
        logic              accept;
        logic              mac;
        logic              clear_sum;
        logic              add_bias;
        logic              clear_total;
        logic              scale;
        logic              emit;
        logic [TAP_AW-1:0] tap_addr;
        logic [MAP_AW-1:0] pos;
        logic [KW_W-1:0]   dx;
        logic [KW_W-1:0]   dy;
        logic [PK_W-1:0]   p;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

### src/bce_ctrl.sv
// sequencer for the board evaluator: input handshake and the filter, square, tap walk
// depends on bce_pkg
`timescale 1ns / 1ps

module bce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    input  logic            i_in_last,
    output logic            o_in_ready,
    input  bce_pkg::t_stat  i_stat,
    output bce_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_BIAS   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_SCORE  = 3'd5;

    localparam int DRAIN_CYCLES = 3;

    logic [2:0]                 r_state, n_state;
    logic [bce_pkg::MAP_AW-1:0] r_pos, n_pos;
    logic [bce_pkg::TAP_AW-1:0] r_tap, n_tap;
    logic [bce_pkg::TAP_AW-1:0] r_base, n_base;
    logic [bce_pkg::KW_W-1:0]   r_dx, n_dx;
    logic [bce_pkg::KW_W-1:0]   r_dy, n_dy;
    logic [bce_pkg::PK_W-1:0]   r_p, n_p;
    logic [1:0]                 r_drain, n_drain;
    logic                       w_accept;
    logic                       w_last_tap;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last_tap = (r_p == bce_pkg::PK_W'(bce_pkg::PIECE_KINDS - 1))
                     && (r_dy == bce_pkg::KW_W'(bce_pkg::KERNEL_WIDTH - 1))
                     && (r_dx == bce_pkg::KW_W'(bce_pkg::KERNEL_WIDTH - 1));

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_tap   = r_tap;
        n_base  = r_base;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_p     = r_p;
        n_drain = r_drain;

        o_cmd             = '0;
        o_cmd.accept      = w_accept;
        o_cmd.tap_addr    = r_tap;
        o_cmd.pos         = r_pos;
        o_cmd.dx          = r_dx;
        o_cmd.dy          = r_dy;
        o_cmd.p           = r_p;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_op == bce_pkg::OP_PLANE) && i_in_last) begin
                    o_cmd.clear_total = 1'b1;
                    n_pos   = '0;
                    n_tap   = '0;
                    n_base  = '0;
                    n_dx    = '0;
                    n_dy    = '0;
                    n_p     = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.mac       = 1'b1;
                o_cmd.clear_sum = (r_dx == '0) && (r_dy == '0) && (r_p == '0);
                if (w_last_tap) begin
                    n_state = S_BIAS;
                end else begin
                    n_tap = r_tap + 1'b1;
                    if (r_p == bce_pkg::PK_W'(bce_pkg::PIECE_KINDS - 1)) begin
                        n_p = '0;
                        if (r_dy == bce_pkg::KW_W'(bce_pkg::KERNEL_WIDTH - 1)) begin
                            n_dy = '0;
                            n_dx = r_dx + 1'b1;
                        end else begin
                            n_dy = r_dy + 1'b1;
                        end
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end
            end
            S_BIAS: begin
                o_cmd.add_bias = 1'b1;
                n_dx = '0;
                n_dy = '0;
                n_p  = '0;
                if (r_pos == bce_pkg::MAP_AW'(bce_pkg::MAP_DEPTH - 1)) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_pos = r_pos + 1'b1;
                    if (r_pos[bce_pkg::SQ_W-1:0] == '1) begin
                        n_base = r_base + bce_pkg::TAP_AW'(bce_pkg::TAPS_PER_FILTER);
                        n_tap  = r_base + bce_pkg::TAP_AW'(bce_pkg::TAPS_PER_FILTER);
                    end else begin
                        n_tap = r_base;
                    end
                    n_state = S_CONV;
                end
            end
            S_DRAIN: begin
                if (r_drain == 2'(DRAIN_CYCLES - 1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SCORE;
            end
            S_SCORE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_tap   <= '0;
            r_base  <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_p     <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_tap   <= n_tap;
            r_base  <= n_base;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_p     <= n_p;
            r_drain <= n_drain;
        end
    end

endmodule

### src/bce_datapath.sv
// weight memories, board planes, convolution and dense accumulators, score register
// depends on bce_pkg; driven by bce_ctrl commands
`timescale 1ns / 1ps

module bce_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bce_pkg::t_cmd                         i_cmd,
    input  logic                                  i_op,
    input  logic [bce_pkg::KIND_W-1:0]            i_weight_kind,
    input  logic [bce_pkg::INDEX_W-1:0]           i_weight_index,
    input  logic signed [bce_pkg::WEIGHT_W-1:0]   i_weight_value,
    input  logic [bce_pkg::PIECE_W-1:0]           i_piece_kind,
    input  logic [bce_pkg::BOARD_W-1:0]           i_own_board,
    input  logic [bce_pkg::BOARD_W-1:0]           i_enemy_board,
    input  logic                                  i_flip_ranks,
    output bce_pkg::t_stat                        o_stat,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bce_pkg::SCORE_W-1:0]    o_score
);

    logic signed [bce_pkg::WEIGHT_W-1:0] r_taps   [bce_pkg::TAP_DEPTH];
    logic signed [bce_pkg::WEIGHT_W-1:0] r_biases [bce_pkg::MAP_DEPTH];
    logic signed [bce_pkg::WEIGHT_W-1:0] r_dense  [bce_pkg::MAP_DEPTH];
    logic [bce_pkg::BOARD_W-1:0]         r_own    [bce_pkg::PIECE_KINDS];
    logic [bce_pkg::BOARD_W-1:0]         r_enemy  [bce_pkg::PIECE_KINDS];
    logic                                r_flip;

    logic signed [bce_pkg::WEIGHT_W-1:0] r_tap_q, r_bias_q, r_dense_q;
    logic                                r_d_mac, r_d_clear, r_d_bias;
    logic signed [1:0]                   r_cell, w_cell;
    logic signed [bce_pkg::SUM_W-1:0]    r_sum, w_sum_base, w_term, w_biased;
    logic signed [bce_pkg::SUM_W-1:0]    r_hid;
    logic signed [bce_pkg::WEIGHT_W-1:0] r_dw;
    logic                                r_a_vld, r_b_vld;
    logic signed [bce_pkg::PROD_W-1:0]   r_prod;
    logic signed [bce_pkg::TOT_W-1:0]    r_total;
    logic signed [bce_pkg::SC_W-1:0]     r_scaled, w_tot_ext;
    logic [bce_pkg::SC_W-1:0]            w_mag, w_shift;
    logic signed [bce_pkg::SCORE_W-1:0]  w_score, r_score;
    logic                                r_out_valid;
    logic                                w_wr_weight, w_wr_plane;
    int                                  w_file, w_rank, w_row;
    logic [bce_pkg::SQ_W-1:0]            w_bit;

    assign w_wr_weight = i_cmd.accept && (i_op == bce_pkg::OP_WEIGHT);
    assign w_wr_plane  = i_cmd.accept && (i_op == bce_pkg::OP_PLANE);

    // weight memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr_weight && (i_weight_kind == bce_pkg::KIND_TAP)
            && (int'(i_weight_index) < bce_pkg::TAP_DEPTH)) begin
            r_taps[bce_pkg::TAP_AW'(i_weight_index)] <= i_weight_value;
        end
        r_tap_q <= r_taps[i_cmd.tap_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_weight && (i_weight_kind == bce_pkg::KIND_BIAS)
            && (int'(i_weight_index) < bce_pkg::MAP_DEPTH)) begin
            r_biases[bce_pkg::MAP_AW'(i_weight_index)] <= i_weight_value;
        end
        r_bias_q <= r_biases[i_cmd.pos];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_weight && (i_weight_kind == bce_pkg::KIND_DENSE)
            && (int'(i_weight_index) < bce_pkg::MAP_DEPTH)) begin
            r_dense[bce_pkg::MAP_AW'(i_weight_index)] <= i_weight_value;
        end
        r_dense_q <= r_dense[i_cmd.pos];
    end

    // board planes, cleared once a score is produced, and rank flip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bce_pkg::PIECE_KINDS; k++) begin
                r_own[k]   <= '0;
                r_enemy[k] <= '0;
            end
            r_flip <= 1'b0;
        end else if (i_cmd.emit) begin
            for (int k = 0; k < bce_pkg::PIECE_KINDS; k++) begin
                r_own[k]   <= '0;
                r_enemy[k] <= '0;
            end
        end else if (w_wr_plane) begin
            if (int'(i_piece_kind) < bce_pkg::PIECE_KINDS) begin
                r_own[bce_pkg::PK_W'(i_piece_kind)]   <= i_own_board;
                r_enemy[bce_pkg::PK_W'(i_piece_kind)] <= i_enemy_board;
            end
            r_flip <= i_flip_ranks;
        end
    end

    // square encoding for the current tap, zero outside the board
    always_comb begin
        w_file = int'(i_cmd.pos[bce_pkg::SQ_W-1:bce_pkg::SIDE_W]) + int'(i_cmd.dx)
               - bce_pkg::PAD_OFFSET;
        w_rank = int'(i_cmd.pos[bce_pkg::SIDE_W-1:0]) + int'(i_cmd.dy)
               - bce_pkg::PAD_OFFSET;
        w_row  = r_flip ? (bce_pkg::BOARD_SIDE - 1 - w_rank) : w_rank;
        w_bit  = bce_pkg::SQ_W'(w_row * bce_pkg::BOARD_SIDE + w_file);
        if (w_file < 0 || w_file >= bce_pkg::BOARD_SIDE
            || w_rank < 0 || w_rank >= bce_pkg::BOARD_SIDE) begin
            w_cell = 2'sd0;
        end else if (r_own[i_cmd.p][w_bit]) begin
            w_cell = 2'sd1;
        end else if (r_enemy[i_cmd.p][w_bit]) begin
            w_cell = -2'sd1;
        end else begin
            w_cell = 2'sd0;
        end
    end

    // convolution accumulate and bias with relu
    always_comb begin
        w_sum_base = r_d_clear ? '0 : r_sum;
        priority if (r_cell == 2'sd1) begin
            w_term = bce_pkg::SUM_W'(r_tap_q);
        end else if (r_cell == -2'sd1) begin
            w_term = -bce_pkg::SUM_W'(r_tap_q);
        end else begin
            w_term = '0;
        end
        w_biased = r_sum + bce_pkg::SUM_W'(r_bias_q);
    end

    // final scaling, truncation toward zero and saturation
    always_comb begin
        w_tot_ext = bce_pkg::SC_W'(r_total);
        w_mag     = r_scaled[bce_pkg::SC_W-1] ? bce_pkg::SC_W'(-r_scaled)
                                              : bce_pkg::SC_W'(r_scaled);
        w_shift   = w_mag >> (2 * bce_pkg::FRACTION_BITS);
        if (r_scaled[bce_pkg::SC_W-1]) begin
            if (w_shift > bce_pkg::SC_W'(8388608)) begin
                w_score = {1'b1, {(bce_pkg::SCORE_W-1){1'b0}}};
            end else begin
                w_score = bce_pkg::SCORE_W'(-w_shift);
            end
        end else begin
            if (w_shift > bce_pkg::SC_W'(8388607)) begin
                w_score = {1'b0, {(bce_pkg::SCORE_W-1){1'b1}}};
            end else begin
                w_score = bce_pkg::SCORE_W'(w_shift);
            end
        end
    end

    // pipeline control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_mac     <= 1'b0;
            r_d_clear   <= 1'b0;
            r_d_bias    <= 1'b0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_mac   <= i_cmd.mac;
            r_d_clear <= i_cmd.clear_sum;
            r_d_bias  <= i_cmd.add_bias;
            r_a_vld   <= r_d_bias;
            r_b_vld   <= r_a_vld;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic payload registers
    always_ff @(posedge i_clk) begin
        r_cell <= w_cell;
        if (r_d_mac) begin
            r_sum <= w_sum_base + w_term;
        end
        if (r_d_bias) begin
            r_hid <= w_biased[bce_pkg::SUM_W-1] ? '0 : w_biased;
            r_dw  <= r_dense_q;
        end
        if (r_a_vld) begin
            r_prod <= bce_pkg::PROD_W'(r_hid) * bce_pkg::PROD_W'(r_dw);
        end
        if (i_cmd.clear_total) begin
            r_total <= '0;
        end else if (r_b_vld) begin
            r_total <= r_total + bce_pkg::TOT_W'(r_prod);
        end
        if (i_cmd.scale) begin
            // times one hundred as 64 + 32 + 4
            r_scaled <= (w_tot_ext <<< 6) + (w_tot_ext <<< 5) + (w_tot_ext <<< 2);
        end
        if (i_cmd.emit) begin
            r_score <= w_score;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_score         = r_score;

endmodule

### src/board_cnn_evaluator.sv
// top level of the board evaluator: stream ports, field unpacking, controller and datapath
// depends on bce_pkg, bce_ctrl and bce_datapath
`timescale 1ns / 1ps

// Board evaluator: scores a position with a 3x3 convolution layer (8 filters, relu, per-square
// bias) and a dense layer, in exact signed Q8.8 arithmetic, returning trunc(net * 100)
// saturated to 24 bits. Requests with tuser 0 write one weight word; requests with tuser 1 load
// one piece plane, and a plane with tlast set starts an evaluation that yields one score. An
// evaluation walks 512 filter-square positions, each with 54 tap accumulations from the tap
// memory read port plus one bias step, and takes no next request until its score is loaded
// into the output register; the score sits in that register until taken. Weights must be
// written before they are used.
module board_cnn_evaluator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // weight_kind[1:0], weight_index[10:2], weight_value[26:11], piece_kind[29:27],
    // own_board[93:30], enemy_board[157:94], flip_ranks[158], zero[159]
    input  logic [bce_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // opcode[0]
    input  logic                                 i_s_axis_tuser,
    // last_plane
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // score[23:0]
    output logic [bce_pkg::SCORE_W-1:0]          o_m_axis_tdata
);

    bce_pkg::t_cmd                       w_cmd;
    bce_pkg::t_stat                      w_stat;
    logic signed [bce_pkg::SCORE_W-1:0]  w_score;

    // sequencer
    bce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // memories and arithmetic
    bce_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_s_axis_tuser),
        .i_weight_kind  (i_s_axis_tdata[bce_pkg::INDEX_LSB-1:bce_pkg::KIND_LSB]),
        .i_weight_index (i_s_axis_tdata[bce_pkg::VALUE_LSB-1:bce_pkg::INDEX_LSB]),
        .i_weight_value (i_s_axis_tdata[bce_pkg::PIECE_LSB-1:bce_pkg::VALUE_LSB]),
        .i_piece_kind   (i_s_axis_tdata[bce_pkg::OWN_LSB-1:bce_pkg::PIECE_LSB]),
        .i_own_board    (i_s_axis_tdata[bce_pkg::ENEMY_LSB-1:bce_pkg::OWN_LSB]),
        .i_enemy_board  (i_s_axis_tdata[bce_pkg::FLIP_LSB-1:bce_pkg::ENEMY_LSB]),
        .i_flip_ranks   (i_s_axis_tdata[bce_pkg::FLIP_LSB]),
        .o_stat         (w_stat),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_score        (w_score)
    );

    assign o_m_axis_tdata = w_score;

endmodule
